// ===== design/uart_baud_divisor_search_top_macros.svh =====
// Assertion macros shared by the checker of the baud divisor search block.
`ifndef UART_BAUD_DIVISOR_SEARCH_TOP_MACROS_SVH
`define UART_BAUD_DIVISOR_SEARCH_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UBDS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubds assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UBDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubds assertion failed");

`endif

// ===== design/ubds_pkg.sv =====
// Package with the constants, codes and types of the baud divisor search block.
package ubds_pkg;

  localparam int MIN_OVERSAMPLE = 4;
  localparam int MAX_OVERSAMPLE = 32;
  localparam int DIVISOR_BITS   = 13;
  localparam int RATIO_SHIFT    = 24;
  localparam int TOLERANCE_PCT  = 3;
  localparam int PERCENT        = 100;

  localparam int CLOCK_BITS  = 32;
  localparam int BAUD_BITS   = 24;
  localparam int RATIO_BITS  = 6;
  localparam int STATUS_BITS = 2;
  localparam int WORD_BITS   = 29;
  localparam int OUT_BITS    = STATUS_BITS + RATIO_BITS + DIVISOR_BITS + WORD_BITS;
  localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;
  localparam int TDATA_BITS  = OUT_BYTES * 8;
  localparam int IN_BYTES    = (BAUD_BITS + 7) / 8;
  localparam int IN_TDATA_BITS = IN_BYTES * 8;

  localparam int NUM_BITS  = CLOCK_BITS + 1;
  localparam int DEN_BITS  = BAUD_BITS + RATIO_BITS;
  localparam int CNT_BITS  = $clog2(NUM_BITS + 1);
  localparam int DR_BITS   = DIVISOR_BITS + RATIO_BITS;
  localparam int PROD_BITS = CLOCK_BITS + 7;
  localparam int TOL_BITS  = BAUD_BITS + 2;

  localparam logic [DIVISOR_BITS-1:0] DIVISOR_MAX = {DIVISOR_BITS{1'b1}};

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_ZERO     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NO_MATCH = 2'd2;

  typedef struct packed {
    logic                start;
    logic [NUM_BITS-1:0] dividend;
    logic [DEN_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/ubds_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, shared by both divisions.
module ubds_divider (
  input  logic               clk,
  input  logic               rst,
  input  ubds_pkg::div_req_t req,
  output ubds_pkg::div_rsp_t rsp
);
  import ubds_pkg::*;

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS-1:0] rem;
  logic [NUM_BITS-1:0] qsh;
  logic                done;
  logic [DEN_BITS:0]   trial;
  logic                ge;

  assign trial = {rem, qsh[NUM_BITS-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_BITS);
        rem  <= '0;
        qsh  <= req.dividend;
        den  <= req.divisor;
      end else if (busy) begin
        if (ge) begin
          rem <= DEN_BITS'(trial - {1'b0, den});
        end else begin
          rem <= trial[DEN_BITS-1:0];
        end
        qsh <= {qsh[NUM_BITS-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = qsh;

endmodule

// ===== design/uart_baud_divisor_search_top.sv =====
// Top level of the baud divisor search: sequencer around one shared serial divider.
//
//  channel   direction  handshake             word contents
//  s_*       in         s_tvalid / s_tready   baud_rate
//  m_*       out        m_tvalid / m_tready   status, oversample, divisor, baud_word
//  cfg_*     in         cfg_valid / cfg_ready clock_hz
//
// Each ratio from 4 to 32 takes two serial divisions plus sequencing states, or only
// the first when its rounded divisor is zero or too wide. A zero clock or baud rate
// skips the search. Reset is synchronous and restores clock_hz to 80000000.
// A finished word waits in the output register while the next baud rate is taken.
module uart_baud_divisor_search_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // baud_rate [23:0]
  input  logic [ubds_pkg::IN_TDATA_BITS-1:0] s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status [1:0], oversample [7:2], divisor [20:8], baud_word [49:21]
  output logic [ubds_pkg::TDATA_BITS-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ubds_pkg::CLOCK_BITS-1:0]    cfg_data
);
  import ubds_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_WAIT1 = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_DIV2  = 4'd5;
  localparam logic [3:0] S_WAIT2 = 4'd6;
  localparam logic [3:0] S_ERR   = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_FMUL  = 4'd9;
  localparam logic [3:0] S_FCMP  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]              state;
  logic [CLOCK_BITS-1:0]   clock_hz;
  logic [BAUD_BITS-1:0]    baud;
  logic [RATIO_BITS-1:0]   ratio;
  logic [DEN_BITS-1:0]     d;
  logic [DIVISOR_BITS-1:0] div_cand;
  logic [DR_BITS-1:0]      dr;
  logic [CLOCK_BITS-1:0]   actual;
  logic                    found;
  logic [CLOCK_BITS-1:0]   least_err;
  logic [RATIO_BITS-1:0]   best_ratio;
  logic [DIVISOR_BITS-1:0] best_div;
  logic [PROD_BITS-1:0]    prod;
  logic [STATUS_BITS-1:0]  res_status;
  logic [RATIO_BITS-1:0]   res_ratio;
  logic [DIVISOR_BITS-1:0] res_div;
  logic [CLOCK_BITS-1:0]   err;
  logic [TOL_BITS-1:0]     tol;
  logic [RATIO_BITS-1:0]   ratio_m1;
  logic [WORD_BITS-1:0]    res_word;
  div_req_t                req;
  div_rsp_t                rsp;

  ubds_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign err      = (actual > {{(CLOCK_BITS-BAUD_BITS){1'b0}}, baud})
                    ? actual - {{(CLOCK_BITS-BAUD_BITS){1'b0}}, baud}
                    : {{(CLOCK_BITS-BAUD_BITS){1'b0}}, baud} - actual;
  assign tol      = TOL_BITS'(baud) * TOL_BITS'(TOLERANCE_PCT);
  assign ratio_m1 = res_ratio - 1'b1;
  assign res_word = (res_status == ST_OK)
                    ? {ratio_m1[WORD_BITS-RATIO_SHIFT-1:0],
                       {(RATIO_SHIFT-DIVISOR_BITS){1'b0}}, res_div}
                    : '0;

  always_comb begin
    req.start    = (state == S_DIV1) || (state == S_DIV2);
    req.dividend = (state == S_DIV1)
                   ? NUM_BITS'(clock_hz) + NUM_BITS'(d >> 1)
                   : NUM_BITS'(clock_hz);
    req.divisor  = (state == S_DIV1) ? d : DEN_BITS'(dr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_BITS'(80000000);
    end else if (cfg_valid && cfg_ready) begin
      clock_hz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            baud  <= s_tdata[BAUD_BITS-1:0];
            ratio <= RATIO_BITS'(MIN_OVERSAMPLE);
            found <= 1'b0;
            if (s_tdata[BAUD_BITS-1:0] == '0 || clock_hz == '0) begin
              res_status <= ST_ZERO;
              res_ratio  <= '0;
              res_div    <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          d     <= DEN_BITS'(baud) * DEN_BITS'(ratio);
          state <= S_DIV1;
        end
        S_DIV1: begin
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (rsp.done) begin
            if (rsp.quotient == '0 || rsp.quotient > NUM_BITS'(DIVISOR_MAX)) begin
              state <= S_NEXT;
            end else begin
              div_cand <= rsp.quotient[DIVISOR_BITS-1:0];
              state    <= S_MUL2;
            end
          end
        end
        S_MUL2: begin
          dr    <= DR_BITS'(div_cand) * DR_BITS'(ratio);
          state <= S_DIV2;
        end
        S_DIV2: begin
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          if (rsp.done) begin
            actual <= rsp.quotient[CLOCK_BITS-1:0];
            state  <= S_ERR;
          end
        end
        S_ERR: begin
          if (!found || err < least_err) begin
            found      <= 1'b1;
            least_err  <= err;
            best_ratio <= ratio;
            best_div   <= div_cand;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (ratio == RATIO_BITS'(MAX_OVERSAMPLE)) begin
            state <= S_FMUL;
          end else begin
            ratio <= ratio + 1'b1;
            state <= S_MUL1;
          end
        end
        S_FMUL: begin
          prod  <= PROD_BITS'(least_err) * PROD_BITS'(PERCENT);
          state <= S_FCMP;
        end
        S_FCMP: begin
          if (!found || prod > PROD_BITS'(tol)) begin
            res_status <= ST_NO_MATCH;
            res_ratio  <= '0;
            res_div    <= '0;
          end else begin
            res_status <= ST_OK;
            res_ratio  <= best_ratio;
            res_div    <= best_div;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDATA_BITS'({res_word, res_div, res_ratio, res_status});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/ubds_checker.sv =====
// Port-level checker of the baud divisor search block, bound to the top level.
`include "uart_baud_divisor_search_top_macros.svh"

module ubds_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [ubds_pkg::TDATA_BITS-1:0]    m_tdata
);
  import ubds_pkg::*;

  logic [STATUS_BITS-1:0] st;
  logic [RATIO_BITS-1:0]  ov;
  logic                   ok_fields;

  assign st = m_tdata[1:0];
  assign ov = m_tdata[7:2];
  assign ok_fields = ov >= RATIO_BITS'(MIN_OVERSAMPLE) && ov <= RATIO_BITS'(MAX_OVERSAMPLE)
                     && m_tdata[33:21] == m_tdata[20:8] && m_tdata[20:8] != '0;

  `UBDS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `UBDS_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready)
  `UBDS_ASSERT_SAME(a_fail_zero, clk, rst, m_tvalid && st != ST_OK, m_tdata[49:2] == '0)
  `UBDS_ASSERT_SAME(a_ok_fields, clk, rst, m_tvalid && st == ST_OK, ok_fields)
  `UBDS_ASSERT_SAME(a_status_code, clk, rst, m_tvalid, st == ST_OK || st == ST_ZERO || st == ST_NO_MATCH)

endmodule

bind uart_baud_divisor_search_top ubds_checker u_ubds_checker (.*);
